[rtl/llq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// llq_pkg - linked-list queue shared types
// Beat payload structs, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package llq_pkg;

    localparam int LLQ_DEPTH      = 16;
    localparam int LLQ_ELEM_WIDTH = 32;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FULL_REJ   = 2'd1,
        ST_EMPTY_REJ  = 2'd2
    } t_status;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] head_value;
        logic               head_valid;
        logic [COUNT_W-1:0] count;
        logic               full_res;
        logic               empty_res;
    } t_result;

endpackage
`default_nettype wire

[rtl/linked_list_queue_with_free_list_top.sv]
`default_nettype none
// A command beat accepted at a clock edge gives its result beat on o_done/o_result in the cycle
// after that edge, valid for that one cycle; the receiver cannot stall.
// One command per cycle while o_busy is low, set by the single register stage around the
// link and element register files (next-link read, then element read, in one pass).
// Reset (synchronous, active low): list links rebuilt to 0->1->...->DEPTH-1, free head 0,
// queue empty; o_busy high from the first reset edge to the first edge after release.
// ----------------------------------------------------------------------------
// linked_list_queue_with_free_list_top - FIFO queue as a linked list with free list
// Nodes live in a small register file; unused nodes chain on a free list. A tail
// pointer and a counter are kept so no list walk is needed.
// ----------------------------------------------------------------------------
module linked_list_queue_with_free_list_top #(
    parameter int DEPTH      = llq_pkg::LLQ_DEPTH,
    parameter int ELEM_WIDTH = llq_pkg::LLQ_ELEM_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire llq_pkg::t_in_item i_item,
    output logic                   o_busy,
    output logic                   o_done,
    output llq_pkg::t_result       o_result
);
    import llq_pkg::*;

    // Pointer width holds every node index plus the null marker (DEPTH).
    localparam int PW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Stored element width: the value port is 32 bits, cut to ELEM_WIDTH when that is smaller.
    localparam int SW = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
    localparam logic [PW-1:0] NIL = PW'(DEPTH);

    // Node storage
    logic [SW-1:0] r_elem  [DEPTH];   // no reset: undefined until written
    logic [PW-1:0] r_link  [DEPTH];

    // List pointers and bookkeeping
    logic [PW-1:0] r_free_head, n_free_head;
    logic [PW-1:0] r_head,      n_head;
    logic [PW-1:0] r_tail,      n_tail;
    logic [PW-1:0] r_count,     n_count;
    logic [SW-1:0] r_head_val,  n_head_val;   // element at head, kept alongside
    logic          r_busy;
    logic          r_done;
    t_result       r_result,    n_result;

    // Write controls for the register files
    logic          elem_we;
    logic [IW-1:0] elem_idx;
    logic          link_we_a, link_we_b;
    logic [IW-1:0] link_idx_a, link_idx_b;
    logic [PW-1:0] link_dat_a, link_dat_b;

    // Pass signals
    logic          accept;
    logic          is_enq;
    logic          free_ok, head_ok, tail_ok;
    logic [PW-1:0] rd_ptr;
    logic [PW-1:0] link_rd;
    logic [PW-1:0] link_norm;
    t_status       status;

    assign accept = i_start && !r_busy;
    assign is_enq = (i_item.operation == OP_ENQ);
    assign free_ok = (r_free_head < NIL);
    assign head_ok = (r_head < NIL);
    assign tail_ok = (r_tail < NIL);

    // One link read a beat: successor of the free head (enqueue) or of the head.
    assign rd_ptr    = is_enq ? r_free_head : r_head;
    assign link_rd   = r_link[rd_ptr[IW-1:0]];
    assign link_norm = (link_rd < NIL) ? link_rd : NIL;   // corrupt link reads as null

    always_comb begin
        n_free_head = r_free_head;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_head_val  = r_head_val;
        status      = ST_DONE;
        elem_we     = 1'b0;
        elem_idx    = r_free_head[IW-1:0];
        link_we_a   = 1'b0;
        link_idx_a  = r_free_head[IW-1:0];
        link_dat_a  = NIL;
        link_we_b   = 1'b0;
        link_idx_b  = r_tail[IW-1:0];
        link_dat_b  = r_free_head;
        if (accept) begin
            if (is_enq) begin
                if (!free_ok) begin
                    status = ST_FULL_REJ;
                end else begin
                    // Take node off the free list, append at tail
                    n_free_head = link_norm;
                    elem_we     = 1'b1;
                    link_we_a   = 1'b1;            // new node terminates list
                    if (!head_ok) begin
                        n_head     = r_free_head;
                        n_head_val = i_item.value[SW-1:0];
                    end else if (tail_ok) begin
                        link_we_b  = 1'b1;         // old tail points at new node
                    end
                    n_tail = r_free_head;
                    if (r_count < NIL) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end else begin
                if (!head_ok) begin
                    status = ST_EMPTY_REJ;
                end else begin
                    // Unlink head, push it onto the front of the free list
                    n_head = link_norm;
                    if (link_norm == NIL) begin
                        n_tail = NIL;
                    end else begin
                        n_head_val = r_elem[link_norm[IW-1:0]];
                    end
                    link_we_a   = 1'b1;
                    link_idx_a  = r_head[IW-1:0];
                    link_dat_a  = r_free_head;
                    n_free_head = r_head;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
        end
    end

    // Result beat describes the queue after this command
    always_comb begin
        n_result.status     = status;
        n_result.head_valid = (n_head < NIL);
        n_result.head_value = (n_head < NIL) ? VALUE_W'(n_head_val) : '0;
        n_result.count      = COUNT_W'(n_count);
        n_result.full_res   = !(n_free_head < NIL);
        n_result.empty_res  = !(n_head < NIL);
    end

    // Control and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_busy      <= 1'b1;
            r_done      <= 1'b0;
        end else begin
            r_free_head <= n_free_head;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_busy      <= 1'b0;
            r_done      <= accept;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_head_val <= n_head_val;
        r_result   <= n_result;
    end

    // Element file: written on enqueue only
    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            r_elem[elem_idx] <= i_item.value[SW-1:0];
        end
    end

    // Link file: reset rebuilds the initial free chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_link[i] <= (i == DEPTH - 1) ? NIL : PW'(i + 1);
            end
        end else begin
            if (link_we_a) begin
                r_link[link_idx_a] <= link_dat_a;
            end
            if (link_we_b) begin
                r_link[link_idx_b] <= link_dat_b;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("count above depth");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == NIL))
        else $error("head pointer disagrees with count");

    a_full_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == NIL) == (r_free_head == NIL))
        else $error("free list disagrees with count");

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("accepted command gave no result beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy))
        else $error("result beat without command");
`endif

endmodule
`default_nettype wire
